### rtl/ces_pkg.sv
// Shared constants and types of the Compton energy spectrum density unit.
`timescale 1ns / 1ps
`default_nettype none
package ces_pkg;

    // 511 keV in raw Q16.8 units and its square
    localparam logic [16:0] REST_RAW    = 17'd130816;
    localparam logic [33:0] REST_RAW_SQ = 34'd17112825856;
    // 2*pi in Q.29
    localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;
    // combined scale 2*pi * 511^2, split into two 33-bit halves for the multiplier
    localparam logic [65:0] SCALE_K     = {34'd0, TWO_PI_Q29} * {32'd0, REST_RAW_SQ};
    localparam logic [32:0] SCALE_LO    = SCALE_K[32:0];
    localparam logic [32:0] SCALE_HI    = SCALE_K[65:33];

    localparam int unsigned FRAC_W      = 32;
    localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;

    localparam int unsigned DENSITY_W   = 40;
    localparam logic [39:0] DENSITY_MAX = 40'hFF_FFFF_FFFF;

    // status that travels with each item behind the scale stages
    typedef struct packed {
        logic zero;  // outside the kinematic range, force density to 0
        logic sat;   // quotient above the density range
    } t_flags;

endpackage
`default_nettype wire

### rtl/compton_energy_spectrum_density_unit.sv
// Top level of the Compton energy spectrum density unit: pipeline and output skid.
`timescale 1ns / 1ps
`default_nettype none
// Klein-Nishina dsigma/dT, one spectrum point per input beat.
//
// Input beat: tuser carries the selector (1 = observed energy is the recoil
// electron, 0 = scattered gamma), tdata carries observed then incident energy,
// unsigned Q16.8 keV. Output beat: tdata is the density, unsigned Q32.8; tuser
// flags a density clipped to its maximum. Out-of-range points give zero.
//
// Throughput: one beat per cycle while the receiver keeps taking beats; a stall
// holds the whole pipeline. The depth is set by two restoring dividers, one
// quotient bit per stage: the cos/T^2 divider (ENERGY_WIDTH + 17 stages) and
// the final divide by E0^2 (40 stages), plus three front and seven scale stages
// and the output register.
//
// Reset clears all valid bits; payload registers are not reset. When the
// receiver stalls, one more beat drains into a skid register, then o_s_tready
// drops and the whole pipeline holds; nothing is lost or repeated.
module compton_energy_spectrum_density_unit #(
    parameter int ENERGY_WIDTH = 24
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // [EW-1:0] observed_energy, [2*EW-1:EW] incident_energy, zero pad above
    input  wire logic [((2*ENERGY_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // [0] func
    input  wire logic                               i_s_tuser,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // [39:0] density
    output logic [ces_pkg::DENSITY_W-1:0]           o_m_tdata,
    // [0] saturated
    output logic                                    o_m_tuser
);

    localparam int EW = ENERGY_WIDTH;
    localparam int DW = 2 * EW;
    localparam int GQ = EW + 17;
    localparam int QB = ces_pkg::DENSITY_W;

    // global advance: all stages move together unless the skid slot is taken
    logic w_en;
    logic r_skid_vld, r_out_vld;
    assign w_en = ~r_skid_vld;

    // front
    logic          w_f_vld, w_f_zero, w_f_q0;
    logic [DW-1:0] w_f_n, w_f_u_rem, w_f_g_rem, w_f_e0sq;
    logic [GQ-1:0] w_f_g_bits;

    ces_front #(.EW(EW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (i_s_tvalid),
        .i_func   (i_s_tuser),
        .i_obs    (i_s_tdata[EW-1:0]),
        .i_e0     (i_s_tdata[2*EW-1:EW]),
        .o_vld    (w_f_vld),
        .o_zero   (w_f_zero),
        .o_q0     (w_f_q0),
        .o_n      (w_f_n),
        .o_u_rem  (w_f_u_rem),
        .o_g_rem  (w_f_g_rem),
        .o_g_bits (w_f_g_bits),
        .o_e0sq   (w_f_e0sq)
    );

    // 1 - cos(theta): extra fraction bits are dropped later, which keeps the floor exact
    logic          w_ud_vld;
    logic [GQ-1:0] w_ud_quo;
    logic          w_ud_q0;

    ces_div_pipe #(.DW(DW), .QW(GQ), .SBW(1)) u_div_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_f_vld),
        .i_den   (w_f_n),
        .i_rem   (w_f_u_rem),
        .i_bits  ('0),
        .i_side  (w_f_q0),
        .o_vld   (w_ud_vld),
        .o_quo   (w_ud_quo),
        .o_side  (w_ud_q0)
    );

    // T^2 / (E0*Y) in Q.32
    logic          w_gd_vld;
    logic [GQ-1:0] w_gd_quo;
    logic [DW:0]   w_gd_side;

    ces_div_pipe #(.DW(DW), .QW(GQ), .SBW(DW+1)) u_div_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_f_vld),
        .i_den   (w_f_n),
        .i_rem   (w_f_g_rem),
        .i_bits  (w_f_g_bits),
        .i_side  ({w_f_zero, w_f_e0sq}),
        .o_vld   (w_gd_vld),
        .o_quo   (w_gd_quo),
        .o_side  (w_gd_side)
    );

    // scale
    logic            w_s_vld;
    ces_pkg::t_flags w_s_flags;
    logic [DW-1:0]   w_s_rem, w_s_e0sq;
    logic [QB-1:0]   w_s_bits;

    ces_scale #(.EW(EW)) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_gd_vld & w_ud_vld),
        .i_zero  (w_gd_side[DW]),
        .i_q0    (w_ud_q0),
        .i_uq    (w_ud_quo),
        .i_g     (w_gd_quo),
        .i_e0sq  (w_gd_side[DW-1:0]),
        .o_vld   (w_s_vld),
        .o_flags (w_s_flags),
        .o_rem   (w_s_rem),
        .o_bits  (w_s_bits),
        .o_e0sq  (w_s_e0sq)
    );

    // final divide by E0^2
    logic            w_d_vld;
    logic [QB-1:0]   w_d_quo;
    logic [1:0]      w_d_side;
    ces_pkg::t_flags w_d_flags;

    ces_div_pipe #(.DW(DW), .QW(QB), .SBW(2)) u_div_e (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_s_vld),
        .i_den   (w_s_e0sq),
        .i_rem   (w_s_rem),
        .i_bits  (w_s_bits),
        .i_side  (w_s_flags),
        .o_vld   (w_d_vld),
        .o_quo   (w_d_quo),
        .o_side  (w_d_side)
    );

    assign w_d_flags = ces_pkg::t_flags'(w_d_side);

    // zero outside the kinematic range, clip on overflow
    logic [QB-1:0] w_density;
    logic          w_sat;
    assign w_density = w_d_flags.zero ? '0 :
                       (w_d_flags.sat ? ces_pkg::DENSITY_MAX : w_d_quo);
    assign w_sat     = ~w_d_flags.zero & w_d_flags.sat;

    // output register plus one skid slot
    logic [QB-1:0] r_out_data, r_skid_data;
    logic          r_out_sat, r_skid_sat;
    logic          w_take;
    assign w_take = r_out_vld & i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_d_vld) begin
            if (r_out_vld && !w_take) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out_data <= r_skid_data;
                r_out_sat  <= r_skid_sat;
            end
        end else if (w_d_vld) begin
            if (r_out_vld && !w_take) begin
                r_skid_data <= w_density;
                r_skid_sat  <= w_sat;
            end else begin
                r_out_data <= w_density;
                r_out_sat  <= w_sat;
            end
        end
    end

    assign o_s_tready = w_en;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_sat;

    // skid slot only fills behind a waiting output beat
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid slot holds a beat while the output register is empty");

    // a stalled skid beat stays until the output moves
    a_skid_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_m_tready) |=> r_skid_vld)
        else $error("skid beat dropped during a stall");

    // a clipped beat carries the maximum density
    a_sat_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == ces_pkg::DENSITY_MAX))
        else $error("saturated beat without maximum density");

endmodule
`default_nettype wire

### rtl/ces_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none
module ces_div_pipe #(
    parameter int DW  = 48,
    parameter int QW  = 40,
    parameter int SBW = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_vld,
    input  wire logic [DW-1:0]  i_den,
    input  wire logic [DW-1:0]  i_rem,   // starting remainder, below i_den
    input  wire logic [QW-1:0]  i_bits,  // dividend bits, MSB fed first
    input  wire logic [SBW-1:0] i_side,
    output logic                o_vld,
    output logic [QW-1:0]       o_quo,
    output logic [SBW-1:0]      o_side
);

    logic           r_vld  [QW];
    logic [DW-1:0]  r_rem  [QW];
    logic [DW-1:0]  r_den  [QW];
    logic [QW-1:0]  r_acc  [QW];  // remaining dividend bits, quotient bits shift in
    logic [SBW-1:0] r_side [QW];

    for (genvar gi = 0; gi < QW; gi++) begin : g_stage
        logic           w_vld_in;
        logic [DW-1:0]  w_rem_in;
        logic [DW-1:0]  w_den_in;
        logic [QW-1:0]  w_acc_in;
        logic [SBW-1:0] w_side_in;
        logic [DW:0]    w_trial;
        logic [DW:0]    w_diff;
        logic           w_ge;

        if (gi == 0) begin : g_head
            assign w_vld_in  = i_vld;
            assign w_rem_in  = i_rem;
            assign w_den_in  = i_den;
            assign w_acc_in  = i_bits;
            assign w_side_in = i_side;
        end else begin : g_body
            assign w_vld_in  = r_vld[gi-1];
            assign w_rem_in  = r_rem[gi-1];
            assign w_den_in  = r_den[gi-1];
            assign w_acc_in  = r_acc[gi-1];
            assign w_side_in = r_side[gi-1];
        end

        assign w_trial = {w_rem_in, w_acc_in[QW-1]};
        assign w_diff  = w_trial - {1'b0, w_den_in};
        assign w_ge    = (w_trial >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gi] <= 1'b0;
            end else if (i_en) begin
                r_vld[gi] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gi]  <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                r_den[gi]  <= w_den_in;
                r_acc[gi]  <= {w_acc_in[QW-2:0], w_ge};
                r_side[gi] <= w_side_in;
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quo  = r_acc[QW-1];
    assign o_side = r_side[QW-1];

endmodule
`default_nettype wire

### rtl/ces_front.sv
// Front stages: range checks, energy products and divider setup.
`timescale 1ns / 1ps
`default_nettype none
module ces_front #(
    parameter int EW = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire logic             i_func,
    input  wire logic [EW-1:0]    i_obs,
    input  wire logic [EW-1:0]    i_e0,
    output logic                  o_vld,
    output logic                  o_zero,
    output logic                  o_q0,
    output logic [2*EW-1:0]       o_n,
    output logic [2*EW-1:0]       o_u_rem,
    output logic [2*EW-1:0]       o_g_rem,
    output logic [EW+16:0]        o_g_bits,
    output logic [2*EW-1:0]       o_e0sq
);

    localparam int DW  = 2 * EW;
    localparam int KW  = EW + 17;
    localparam int NKW = 2 * EW + 1;

    // stage 1: split into electron and scattered gamma energy
    logic          r1_vld, r1_zero;
    logic [EW-1:0] r1_t, r1_y, r1_e0;
    logic [EW-1:0] w1_diff;
    logic          w1_zero;

    assign w1_diff = i_e0 - i_obs;
    assign w1_zero = (i_obs == '0) || (i_e0 == '0) || (i_obs >= i_e0);

    // stage 2: products
    logic          r2_vld, r2_zero;
    logic [DW-1:0] r2_n, r2_e0sq, r2_tsq;
    logic [KW-1:0] r2_k;

    // stage 3: Compton edge and divider setup
    logic           r3_vld, r3_zero, r3_q0;
    logic [DW-1:0]  r3_n, r3_u_rem, r3_g_rem, r3_e0sq;
    logic [KW-1:0]  r3_g_bits;
    logic [NKW-1:0] w3_k, w3_n, w3_kmn;
    logic           w3_edge, w3_q0;

    assign w3_k    = NKW'(r2_k);
    assign w3_n    = NKW'(r2_n);
    assign w3_kmn  = w3_k - w3_n;
    assign w3_edge = (w3_k >= (w3_n << 1));
    assign w3_q0   = (w3_k >= w3_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_zero <= w1_zero;
            r1_e0   <= i_e0;
            r1_t    <= i_func ? i_obs : w1_diff;
            r1_y    <= i_func ? w1_diff : i_obs;

            r2_zero <= r1_zero;
            r2_n    <= DW'(r1_e0) * DW'(r1_y);
            r2_e0sq <= DW'(r1_e0) * DW'(r1_e0);
            r2_tsq  <= DW'(r1_t) * DW'(r1_t);
            r2_k    <= KW'(ces_pkg::REST_RAW) * KW'(r1_t);

            r3_zero   <= r2_zero | w3_edge;
            r3_q0     <= w3_q0;
            r3_n      <= r2_n;
            r3_u_rem  <= w3_q0 ? w3_kmn[DW-1:0] : w3_k[DW-1:0];
            r3_g_rem  <= r2_tsq >> (EW - 15);
            r3_g_bits <= {r2_tsq[EW-16:0], 32'd0};
            r3_e0sq   <= r2_e0sq;
        end
    end

    assign o_vld    = r3_vld;
    assign o_zero   = r3_zero;
    assign o_q0     = r3_q0;
    assign o_n      = r3_n;
    assign o_u_rem  = r3_u_rem;
    assign o_g_rem  = r3_g_rem;
    assign o_g_bits = r3_g_bits;
    assign o_e0sq   = r3_e0sq;

endmodule
`default_nettype wire

### rtl/ces_scale.sv
// Middle stages: cos^2 term, sum, constant scale multiply and range check.
`timescale 1ns / 1ps
`default_nettype none
module ces_scale #(
    parameter int EW = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_vld,
    input  wire logic                  i_zero,
    input  wire logic                  i_q0,
    input  wire logic [EW+16:0]        i_uq,
    input  wire logic [EW+16:0]        i_g,
    input  wire logic [2*EW-1:0]       i_e0sq,
    output logic                       o_vld,
    output ces_pkg::t_flags            o_flags,
    output logic [2*EW-1:0]            o_rem,
    output logic [ces_pkg::DENSITY_W-1:0] o_bits,
    output logic [2*EW-1:0]            o_e0sq
);

    localparam int GQ = EW + 17;
    localparam int SW = EW + 18;
    localparam int PW = SW + 66;
    localparam int XW = PW - 53;
    localparam int DW = 2 * EW;
    localparam int HW = SW - 32;
    localparam int QB = ces_pkg::DENSITY_W;

    logic        r_vld [7];
    logic        r_zero [7];
    logic [DW-1:0] r_e0sq [7];

    // stage 1: |1 - u| in Q1.32
    logic [32:0] w1_u;
    logic [32:0] r1_w;
    logic [GQ-1:0] r1_g, r2_g;
    assign w1_u = {i_q0, i_uq[GQ-1 -: 32]};

    // stage 2: cos^2
    logic [63:0] w2_sq;
    logic [32:0] r2_c2;
    assign w2_sq = 64'(r1_w[31:0]) * 64'(r1_w[31:0]);

    // stage 3: S = 1 + cos^2 + T^2/(E0*Y)
    logic [SW-1:0] r3_s;

    // stage 4: partial products against the scale constant
    logic [64:0]   r4_pp00, r4_pp01;
    logic [HW+32:0] r4_pp10, r4_pp11;

    // stage 5, 6: sum partial products, drop 53 bits
    logic [PW-1:0] r5_lo, r5_hi;
    logic [PW-1:0] w6_p;
    logic [XW-1:0] r6_x;
    assign w6_p = r5_lo + (r5_hi << 33);

    // stage 7: saturation check, final divider setup
    logic [DW-1:0] w7_top;
    logic          r7_sat;
    logic [DW-1:0] r7_rem;
    logic [QB-1:0] r7_bits;
    assign w7_top = DW'(r6_x[XW-1:QB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 7; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int i = 1; i < 7; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= i_zero;
            r_e0sq[0] <= i_e0sq;
            for (int i = 1; i < 7; i++) begin
                r_zero[i] <= r_zero[i-1];
                r_e0sq[i] <= r_e0sq[i-1];
            end

            r1_w  <= w1_u[32] ? {1'b0, w1_u[31:0]} : (ces_pkg::ONE_Q32 - w1_u);
            r1_g  <= i_g;

            r2_c2 <= r1_w[32] ? ces_pkg::ONE_Q32 : {1'b0, w2_sq[63:32]};
            r2_g  <= r1_g;

            r3_s  <= SW'(ces_pkg::ONE_Q32) + SW'(r2_c2) + SW'(r2_g);

            r4_pp00 <= 65'(r3_s[31:0]) * 65'(ces_pkg::SCALE_LO);
            r4_pp01 <= 65'(r3_s[31:0]) * 65'(ces_pkg::SCALE_HI);
            r4_pp10 <= (HW+33)'(r3_s[SW-1:32]) * (HW+33)'(ces_pkg::SCALE_LO);
            r4_pp11 <= (HW+33)'(r3_s[SW-1:32]) * (HW+33)'(ces_pkg::SCALE_HI);

            r5_lo <= PW'(r4_pp00) + (PW'(r4_pp10) << 32);
            r5_hi <= PW'(r4_pp01) + (PW'(r4_pp11) << 32);

            r6_x  <= w6_p[PW-1:53];

            r7_sat  <= (w7_top >= r_e0sq[5]);
            r7_rem  <= w7_top;
            r7_bits <= r6_x[QB-1:0];
        end
    end

    assign o_vld      = r_vld[6];
    assign o_flags.zero = r_zero[6];
    assign o_flags.sat  = r7_sat;
    assign o_rem      = r7_rem;
    assign o_bits     = r7_bits;
    assign o_e0sq     = r_e0sq[6];

endmodule
`default_nettype wire
